>>> rtl/olist_pkg.sv
// olist_pkg: shared types, codes and sizing constants for the ordered list engine.
// No dependencies; imported by olist_cell and ordered_list_engine_unit.
`timescale 1ns / 1ps

package olist_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = 5;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_SEARCH = 2'd2,
        OP_REMOVE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [DATA_W-1:0]   value;
        logic [POS_W-1:0]           position;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   result_value;
        logic                       found;
        status_t                    status;
        logic [4:0]                 entry_count;
    } out_item_t;

    typedef struct packed {
        cell_cmd_t                  cmd;
        logic                       search;
        logic                       sweep;
        logic                       clear;
        logic [CMP_W-1:0]           pos;
        logic [CMP_W-1:0]           count;
        logic [DATA_W-1:0]          value;
    } cell_ctrl_t;

    typedef struct packed {
        logic                       hit;
        logic [DATA_W-1:0]          data;
    } carry_t;

endpackage

>>> rtl/olist_cell.sv
// olist_cell: one list slot. Holds one entry, shifts with its neighbors on
// insert/remove, and forwards a hit/data carry along the chain. Uses olist_pkg.
`timescale 1ns / 1ps

module olist_cell
    import olist_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [IDX_W-1:0]    cell_idx,
    input  cell_ctrl_t          ctrl,
    input  logic [DATA_W-1:0]   prev_entry,
    input  logic [DATA_W-1:0]   next_entry,
    input  carry_t              carry_in,
    output logic [DATA_W-1:0]   entry,
    output carry_t              carry_out
);

    logic [DATA_W-1:0] entry_reg, entry_next;
    carry_t            carry_reg, carry_next;
    logic [CMP_W-1:0]  idx_ext;
    logic              local_hit;

    assign idx_ext = CMP_W'(cell_idx);

    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.cmd)
            CMD_HOLD: begin
            end
            CMD_APPEND: begin
                if (idx_ext == ctrl.count) begin
                    entry_next = ctrl.value;
                end
            end
            CMD_INSERT: begin
                if (idx_ext == ctrl.pos) begin
                    entry_next = ctrl.value;
                end else if (idx_ext > ctrl.pos) begin
                    entry_next = prev_entry;
                end
            end
            CMD_REMOVE: begin
                if (idx_ext >= ctrl.pos) begin
                    entry_next = next_entry;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (ctrl.search) begin
            local_hit = (idx_ext < ctrl.count) && (entry_reg == ctrl.value);
        end else begin
            local_hit = (idx_ext == ctrl.pos);
        end
        carry_next = carry_reg;
        if (ctrl.clear) begin
            carry_next = '0;
        end else if (ctrl.sweep) begin
            if (carry_in.hit) begin
                carry_next = carry_in;
            end else begin
                carry_next.hit  = local_hit;
                carry_next.data = entry_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= '0;
        end else begin
            carry_reg <= carry_next;
        end
    end

    assign entry     = entry_reg;
    assign carry_out = carry_reg;

endmodule

>>> rtl/ordered_list_engine_unit.sv
// ordered_list_engine_unit: top level of the ordered list engine.
// Chain of olist_cell slots plus the operation sequencer. Uses olist_pkg.
//
// Usage:
//   Input items (s_data: opcode, value, position) transfer on s_valid && s_ready;
//   each gives exactly one result (m_data: result_value, found, status,
//   entry_count) that transfers on m_valid && m_ready.
//   Append and insert update the cell chain in the accept cycle; the result is
//   valid the next cycle, and a new item may transfer every cycle while results
//   are read out. Search and remove send a hit/data carry down the chain of
//   LIST_DEPTH cells, one cell per cycle, in the sweep state, then the result is
//   written from the done state; s_ready stays low meanwhile. Search or remove on
//   an empty list, or a remove out of range, finishes without a sweep like append.
//   Results sit in an output register; a new item is taken while the previous
//   result is being read out. If m_ready stays low the result holds, s_ready
//   drops, and a finishing search or remove waits until the register frees.
//   Reset (aresetn low, synchronous) empties the list and drops m_valid; entry
//   storage is not cleared, entries past the count are never read.
`timescale 1ns / 1ps

module ordered_list_engine_unit
    import olist_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_DONE  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    opcode_t            op_reg, op_next;
    logic [DATA_W-1:0]  key_reg, key_next;
    logic [CMP_W-1:0]   pos_reg, pos_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    cell_ctrl_t         ctrl;
    out_item_t          res;
    logic               accept;
    logic               out_free;
    logic               go_out;
    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   pos_ext;
    logic               full;
    logic               empty;

    logic [DATA_W-1:0]  entry_w [LIST_DEPTH];
    carry_t             carry_w [LIST_DEPTH];

    assign count_ext = CMP_W'(count_reg);
    assign pos_ext   = CMP_W'(s_data.position);
    assign full      = (count_ext == CMP_W'(LIST_DEPTH));
    assign empty     = (count_reg == '0);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign accept    = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        go_out       = 1'b0;

        ctrl.cmd    = CMD_HOLD;
        ctrl.search = (op_reg == OP_SEARCH);
        ctrl.sweep  = 1'b0;
        ctrl.clear  = 1'b0;
        ctrl.pos    = pos_reg;
        ctrl.count  = count_ext;
        ctrl.value  = key_reg;

        res.result_value = '0;
        res.found        = 1'b0;
        res.status       = ST_OK;
        res.entry_count  = count_ext[4:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = s_data.opcode;
                    key_next   = s_data.value;
                    pos_next   = pos_ext;
                    ctrl.value = s_data.value;
                    ctrl.pos   = pos_ext;
                    go_out     = 1'b1;
                    unique case (s_data.opcode)
                        OP_APPEND: begin
                            if (full) begin
                                res.status = ST_FULL;
                            end else begin
                                ctrl.cmd        = CMD_APPEND;
                                count_next      = CNT_W'(count_reg + 1'b1);
                                res.entry_count = CMP_W'(count_next) & 5'h1f;
                            end
                        end
                        OP_INSERT: begin
                            if (full) begin
                                res.status = ST_FULL;
                            end else if (pos_ext > count_ext) begin
                                res.status = ST_RANGE;
                            end else begin
                                ctrl.cmd        = CMD_INSERT;
                                count_next      = CNT_W'(count_reg + 1'b1);
                                res.entry_count = CMP_W'(count_next) & 5'h1f;
                            end
                        end
                        OP_SEARCH: begin
                            if (empty) begin
                                res.status = ST_EMPTY;
                            end else begin
                                go_out     = 1'b0;
                                ctrl.clear = 1'b1;
                                cnt_next   = IDX_W'(LIST_DEPTH - 1);
                                state_next = S_SWEEP;
                            end
                        end
                        OP_REMOVE: begin
                            if (empty) begin
                                res.status = ST_EMPTY;
                            end else if (pos_ext >= count_ext) begin
                                res.status = ST_RANGE;
                            end else begin
                                go_out     = 1'b0;
                                ctrl.clear = 1'b1;
                                cnt_next   = IDX_W'(LIST_DEPTH - 1);
                                state_next = S_SWEEP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                ctrl.sweep = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    go_out     = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_REMOVE) begin
                        ctrl.cmd         = CMD_REMOVE;
                        count_next       = CNT_W'(count_reg - 1'b1);
                        res.result_value = carry_w[LIST_DEPTH-1].data;
                        res.entry_count  = CMP_W'(count_next) & 5'h1f;
                    end else if (carry_w[LIST_DEPTH-1].hit) begin
                        res.result_value = carry_w[LIST_DEPTH-1].data;
                        res.found        = 1'b1;
                    end else begin
                        res.status = ST_NOTFOUND;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (go_out) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
            logic [DATA_W-1:0] prev_e;
            logic [DATA_W-1:0] next_e;
            carry_t            c_in;
            if (gi == 0) begin : g_first
                assign prev_e = '0;
                assign c_in   = '0;
            end else begin : g_mid
                assign prev_e = entry_w[gi-1];
                assign c_in   = carry_w[gi-1];
            end
            if (gi == LIST_DEPTH - 1) begin : g_last
                assign next_e = '0;
            end else begin : g_nlast
                assign next_e = entry_w[gi+1];
            end
            olist_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cell_idx   (IDX_W'(gi)),
                .ctrl       (ctrl),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .carry_in   (c_in),
                .entry      (entry_w[gi]),
                .carry_out  (carry_w[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sim/tb_ordered_list_engine_unit.sv
// tb_ordered_list_engine_unit: self-checking testbench for the ordered list engine.
// Directed and random transfers against a cycle-free list predictor; needs olist_pkg
// and ordered_list_engine_unit.
`timescale 1ns / 1ps

module tb_ordered_list_engine_unit;
    import olist_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    logic signed [DATA_W-1:0] model_list [LIST_DEPTH];
    int        model_count = 0;
    out_item_t pending_results [$];
    int        fail_count     = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_left      = 0;

    ordered_list_engine_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Expected result of one operation; updates the predicted list.
    function automatic out_item_t list_apply(in_item_t it);
        out_item_t r;
        int        i;
        int        hit;
        r = '0;
        r.status = ST_OK;
        case (it.opcode)
            OP_APPEND: begin
                if (model_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    model_list[model_count] = it.value;
                    model_count++;
                end
            end
            OP_INSERT: begin
                if (model_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (int'(it.position) > model_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = model_count; i > int'(it.position); i--)
                        model_list[i] = model_list[i-1];
                    model_list[it.position] = it.value;
                    model_count++;
                end
            end
            OP_SEARCH: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    hit = -1;
                    for (i = 0; i < model_count; i++)
                        if (hit < 0 && model_list[i] == it.value)
                            hit = i;
                    if (hit >= 0) begin
                        r.result_value = model_list[hit];
                        r.found        = 1'b1;
                    end else begin
                        r.status = ST_NOTFOUND;
                    end
                end
            end
            OP_REMOVE: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(it.position) >= model_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.result_value = model_list[it.position];
                    for (i = int'(it.position); i + 1 < model_count; i++)
                        model_list[i] = model_list[i+1];
                    model_count--;
                end
            end
        endcase
        r.entry_count = 5'(model_count);
        return r;
    endfunction

    function automatic in_item_t make_item(opcode_t op, logic signed [DATA_W-1:0] v, int pos);
        in_item_t it;
        it.opcode   = op;
        it.value    = v;
        it.position = POS_W'(pos);
        return it;
    endfunction

    // One input transfer; called at a rising edge, returns at the accepting edge.
    task automatic offer_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(list_apply(it));
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        out_item_t seen;
        seen = m_data;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: val=%0d found=%0b status=%0d count=%0d",
                             seen.result_value, seen.found, seen.status, seen.entry_count);
            end else begin
                want = pending_results.pop_front();
                if (seen.result_value !== want.result_value || seen.found !== want.found ||
                    seen.status !== want.status || seen.entry_count !== want.entry_count) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected val=%0d found=%0b status=%0d count=%0d, got val=%0d found=%0b status=%0d count=%0d",
                                 want.result_value, want.found, want.status, want.entry_count,
                                 seen.result_value, seen.found, seen.status, seen.entry_count);
                end
            end
        end
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_empty_list();
        offer_item(make_item(OP_SEARCH, 32'sd5, 0));
        offer_item(make_item(OP_REMOVE, 32'sd0, 0));
        offer_item(make_item(OP_INSERT, 32'sd7, 1));
    endtask

    task automatic test_extremes();
        offer_item(make_item(OP_APPEND, 32'h8000_0000, 0));
        offer_item(make_item(OP_APPEND, 32'h7fff_ffff, 0));
        offer_item(make_item(OP_INSERT, 32'sd0, 0));
        offer_item(make_item(OP_INSERT, -32'sd1, 3));
        offer_item(make_item(OP_INSERT, 32'h5555_5555, 2));
        offer_item(make_item(OP_INSERT, 32'h1234_5678, 31));
    endtask

    task automatic test_search();
        offer_item(make_item(OP_SEARCH, 32'h7fff_ffff, 0));
        offer_item(make_item(OP_SEARCH, 32'haaaa_aaaa, 0));
        offer_item(make_item(OP_APPEND, 32'sd0, 0));
        offer_item(make_item(OP_SEARCH, 32'sd0, 0));
    endtask

    task automatic test_remove();
        offer_item(make_item(OP_REMOVE, 32'sd0, 31));
        offer_item(make_item(OP_REMOVE, 32'sd0, model_count));
        offer_item(make_item(OP_REMOVE, 32'sd0, 0));
        offer_item(make_item(OP_REMOVE, 32'sd0, model_count - 1));
        offer_item(make_item(OP_REMOVE, 32'sd0, 1));
    endtask

    task automatic test_full_list();
        while (model_count < LIST_DEPTH)
            offer_item(make_item(OP_APPEND, $urandom, 0));
        offer_item(make_item(OP_APPEND, 32'sd1, 0));
        offer_item(make_item(OP_INSERT, 32'sd1, 31));
        offer_item(make_item(OP_REMOVE, 32'sd0, LIST_DEPTH - 1));
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        int n;
        send_idle_pct = 0;
        hold_left <= 150;
        for (n = 0; n < 40; n++)
            offer_item(make_item((n % 3 == 2) ? OP_SEARCH : OP_APPEND, $urandom_range(7), 0));
    endtask

    // Alternates between filling and draining so both list edges are hit often.
    task automatic test_random(int count, int idle_pct, int stall_pct);
        int       n;
        int       r;
        bit       filling;
        opcode_t  op;
        logic signed [DATA_W-1:0] v;
        int       pos;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        filling = 1'b1;
        for (n = 0; n < count; n++) begin
            if (model_count == LIST_DEPTH && $urandom_range(3) == 0)
                filling = 1'b0;
            if (model_count == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            r = $urandom_range(99);
            if (filling)
                op = (r < 35) ? OP_APPEND : (r < 65) ? OP_INSERT : (r < 80) ? OP_SEARCH : OP_REMOVE;
            else
                op = (r < 10) ? OP_APPEND : (r < 25) ? OP_INSERT : (r < 45) ? OP_SEARCH : OP_REMOVE;
            r = $urandom_range(99);
            if (r < 35 && model_count > 0)
                v = model_list[$urandom_range(model_count - 1)];
            else if (r < 45)
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            else if (r < 55)
                v = $urandom_range(7);
            else
                v = $urandom;
            if ($urandom_range(99) < 80)
                pos = $urandom_range(model_count);
            else
                pos = $urandom_range(31);
            offer_item(make_item(op, v, pos));
        end
    endtask

    initial begin
        int guard;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct  = 15;
        recv_stall_pct = 55;
        test_empty_list();
        test_extremes();
        test_search();
        test_remove();
        test_full_list();
        test_backpressure();
        test_random(340, 15, 55);
        test_random(340, 55, 15);
        test_random(340, 0, 0);
        s_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 50000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (LIST_DEPTH + 8) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
